// ===== design/vpc_pkg.sv =====
package vpc_pkg;

  localparam int VIP_ENTRIES_DEF = 4;
  localparam int QUEUES_DEF      = 4;
  localparam int FIFO_DEPTH      = 2;

  localparam int KEY_W  = 128;
  localparam int MASK_W = 4;

  localparam logic OP_PACKET      = 1'b0;
  localparam logic OP_TABLE_WRITE = 1'b1;

  localparam logic [2:0] ACT_ABORTED  = 3'd0;
  localparam logic [2:0] ACT_DROP     = 3'd1;
  localparam logic [2:0] ACT_PASS     = 3'd2;
  localparam logic [2:0] ACT_TX       = 3'd3;
  localparam logic [2:0] ACT_REDIRECT = 3'd4;

  localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6  = 16'h86DD;
  localparam logic [15:0] IPV4_MAPPED = 16'hffff;

  // Byte positions inside the frame
  localparam logic [6:0] POS_ETYPE_HI  = 7'd12;
  localparam logic [6:0] POS_ETYPE_LO  = 7'd13;
  localparam logic [6:0] POS_MIN_LAST  = 7'd14;
  localparam logic [6:0] POS_V4_FIRST  = 7'd30;
  localparam logic [6:0] POS_V4_LAST   = 7'd33;
  localparam logic [6:0] POS_V4_END    = 7'd34;
  localparam logic [6:0] POS_V6_FIRST  = 7'd38;
  localparam logic [6:0] POS_V6_LAST   = 7'd53;
  localparam logic [6:0] POS_V6_END    = 7'd54;
  localparam logic [6:0] POS_SATURATED = 7'd127;

  typedef enum logic {
    JOB_WRITE,
    JOB_FRAME
  } job_kind_t;

  typedef enum logic [1:0] {
    CLS_PASS,
    CLS_ABORT,
    CLS_LOOKUP
  } frame_class_t;

  typedef struct packed {
    logic        operation;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [7:0]  rx_queue;
    logic [1:0]  entry_index;
    logic [63:0] entry_key_high;
    logic [63:0] entry_key_low;
    logic [2:0]  entry_action;
    logic        entry_valid;
  } item_t;

  typedef struct packed {
    logic [2:0] action;
    logic       address_matched;
  } result_t;

  typedef struct packed {
    job_kind_t        kind;
    frame_class_t     cls;
    logic [KEY_W-1:0] key;
    logic [7:0]       queue;
    logic [1:0]       index;
    logic [2:0]       entry_action;
    logic             entry_valid;
  } job_t;

endpackage

// ===== design/vpc_front.sv =====
module vpc_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  vpc_pkg::item_t item,
  output logic           push,
  output vpc_pkg::job_t  job,
  input  logic           full
);
  import vpc_pkg::*;

  logic [6:0]       byte_position, byte_position_next;
  logic [15:0]      ether_type, ether_type_next;
  logic [KEY_W-1:0] dest_address, dest_address_next;
  logic [7:0]       frame_queue, frame_queue_next;
  logic             accept, is_packet, frame_ok;

  assign item_stall = full;
  assign accept     = item_valid && !full;
  assign is_packet  = item.operation == OP_PACKET;

  always_comb begin
    byte_position_next = byte_position;
    ether_type_next    = ether_type;
    dest_address_next  = dest_address;
    frame_queue_next   = frame_queue;
    if (accept && is_packet) begin
      if (byte_position == 7'd0) begin
        frame_queue_next  = item.rx_queue;
        ether_type_next   = 16'd0;
        dest_address_next = '0;
      end
      if (byte_position == POS_ETYPE_HI || byte_position == POS_ETYPE_LO) begin
        ether_type_next = {ether_type_next[7:0], item.data_byte};
      end
      if ((ether_type == ETYPE_IPV4 && byte_position >= POS_V4_FIRST &&
           byte_position <= POS_V4_LAST) ||
          (ether_type == ETYPE_IPV6 && byte_position >= POS_V6_FIRST &&
           byte_position <= POS_V6_LAST)) begin
        dest_address_next = {dest_address_next[KEY_W-9:0], item.data_byte};
      end
      if (item.last_byte) begin
        byte_position_next = 7'd0;
      end else if (byte_position != POS_SATURATED) begin
        byte_position_next = byte_position + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 7'd0;
      ether_type    <= 16'd0;
      dest_address  <= '0;
      frame_queue   <= 8'd0;
    end else begin
      byte_position <= byte_position_next;
      ether_type    <= ether_type_next;
      dest_address  <= dest_address_next;
      frame_queue   <= frame_queue_next;
    end
  end

  // The EtherType register is final once the frame reaches the minimum length
  assign frame_ok = (ether_type == ETYPE_IPV6) ? (byte_position >= POS_V6_END)
                                               : (byte_position >= POS_V4_END);

  assign push = accept && (!is_packet || item.last_byte);

  always_comb begin
    job.kind         = is_packet ? JOB_FRAME : JOB_WRITE;
    job.cls          = CLS_PASS;
    job.queue        = (byte_position == 7'd0) ? item.rx_queue : frame_queue;
    job.index        = item.entry_index;
    job.entry_action = item.entry_action;
    job.entry_valid  = item.entry_valid;
    if (byte_position >= POS_MIN_LAST &&
        (ether_type == ETYPE_IPV4 || ether_type == ETYPE_IPV6)) begin
      job.cls = frame_ok ? CLS_LOOKUP : CLS_ABORT;
    end
    if (!is_packet) begin
      job.key = {item.entry_key_high, item.entry_key_low};
    end else if (ether_type == ETYPE_IPV6) begin
      job.key = dest_address_next;
    end else begin
      job.key = {64'd0, 16'd0, IPV4_MAPPED, dest_address_next[31:0]};
    end
  end

endmodule

// ===== design/vpc_fifo.sv =====
module vpc_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  vpc_pkg::job_t wr_job,
  output logic          full,
  output logic          not_empty,
  input  logic          pop,
  output vpc_pkg::job_t rd_job
);
  import vpc_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);

  job_t             slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign full      = count == (PTR_W+1)'(FIFO_DEPTH);
  assign not_empty = count != '0;
  assign rd_job    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/vpc_back.sv =====
module vpc_back #(
  parameter int VIP_ENTRIES = vpc_pkg::VIP_ENTRIES_DEF,
  parameter int QUEUES      = vpc_pkg::QUEUES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       job_valid,
  input  vpc_pkg::job_t              job,
  output logic                       pop,
  output logic                       result_valid,
  input  logic                       result_stall,
  output vpc_pkg::result_t           result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [vpc_pkg::MASK_W-1:0] cfg_data
);
  import vpc_pkg::*;

  localparam logic [MASK_W-1:0] QUEUE_MASK =
    (QUEUES >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((1 << QUEUES) - 1);

  logic [KEY_W-1:0]  vip_keys    [VIP_ENTRIES];
  logic [2:0]        vip_actions [VIP_ENTRIES];
  logic [VIP_ENTRIES-1:0] vip_valid;
  logic [MASK_W-1:0] socket_queue_mask;

  logic       out_free, write_pop, frame_pop, found, redirect_ok;
  logic [2:0] sel_action;
  result_t    verdict;

  assign cfg_ready = 1'b1;
  assign out_free  = !result_valid || !result_stall;
  assign pop       = job_valid && (job.kind == JOB_WRITE || out_free);
  assign write_pop = pop && job.kind == JOB_WRITE;
  assign frame_pop = pop && job.kind == JOB_FRAME;

  always_ff @(posedge clk) begin
    if (rst) begin
      socket_queue_mask <= '0;
    end else if (cfg_valid) begin
      socket_queue_mask <= cfg_data & QUEUE_MASK;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < VIP_ENTRIES; i++) begin
      if (write_pop && 32'(job.index) == 32'(i)) begin
        vip_keys[i]    <= job.key;
        vip_actions[i] <= job.entry_action;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vip_valid <= '0;
    end else begin
      for (int i = 0; i < VIP_ENTRIES; i++) begin
        if (write_pop && 32'(job.index) == 32'(i)) begin
          vip_valid[i] <= job.entry_valid;
        end
      end
    end
  end

  // Scan from the top so the lowest matching slot wins
  always_comb begin
    found      = 1'b0;
    sel_action = ACT_PASS;
    for (int i = VIP_ENTRIES - 1; i >= 0; i--) begin
      if (vip_valid[i] && vip_keys[i] == job.key) begin
        found      = 1'b1;
        sel_action = vip_actions[i];
      end
    end
  end

  assign redirect_ok = job.queue < 8'(MASK_W) && socket_queue_mask[job.queue[1:0]];

  always_comb begin
    verdict.action          = ACT_PASS;
    verdict.address_matched = 1'b0;
    case (job.cls)
      CLS_ABORT: verdict.action = ACT_ABORTED;
      CLS_LOOKUP: begin
        if (found) begin
          verdict.address_matched = 1'b1;
          if (redirect_ok) begin
            verdict.action = ACT_REDIRECT;
          end else if (sel_action <= ACT_REDIRECT) begin
            verdict.action = sel_action;
          end else begin
            verdict.action = ACT_DROP;
          end
        end
      end
      default: verdict.action = ACT_PASS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (frame_pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_pop) begin
      result <= verdict;
    end
  end

endmodule

// ===== design/vip_packet_classifier.sv =====
// Destination-address filter for Ethernet frames. Frame bytes and table-write
// beats share one input channel and are accepted one per cycle; the channel
// stalls only while the two-entry job queue between the parser and the lookup
// stage is full, which happens when the result side stalls. The verdict of a
// frame passes through the queue register, then the result register, after
// its last byte is accepted, and the four-slot key compare is combinational.
// Table writes take effect in order with the frames around them: a frame
// whose last byte came before a write is looked up in the old table. The
// socket queue mask is written through the configuration channel, which is
// always ready, and should be written only while no frame is in flight.
module vip_packet_classifier #(
  parameter int VIP_ENTRIES = vpc_pkg::VIP_ENTRIES_DEF,
  parameter int QUEUES      = vpc_pkg::QUEUES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  vpc_pkg::item_t             item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output vpc_pkg::result_t           result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [vpc_pkg::MASK_W-1:0] cfg_data
);
  import vpc_pkg::*;

  job_t front_job, head_job;
  logic push, full, not_empty, pop;

  vpc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push       (push),
    .job        (front_job),
    .full       (full)
  );

  vpc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_job    (front_job),
    .full      (full),
    .not_empty (not_empty),
    .pop       (pop),
    .rd_job    (head_job)
  );

  vpc_back #(
    .VIP_ENTRIES (VIP_ENTRIES),
    .QUEUES      (QUEUES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (not_empty),
    .job          (head_job),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  a_no_hit_verdict : assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.address_matched |->
      result.action == ACT_PASS || result.action == ACT_ABORTED)
    else $error("verdict without a table hit is neither pass nor aborted");

  a_redirect_needs_hit : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.action == ACT_REDIRECT |-> result.address_matched)
    else $error("redirect without a table hit");

  a_result_from_frame : assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(pop && head_job.kind == JOB_FRAME))
    else $error("result raised without a frame job leaving the queue");

  a_pop_nonempty : assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("job queue popped while empty");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import vpc_pkg::*;

  localparam int SLOTS        = VIP_ENTRIES_DEF;
  localparam int RX_QUEUES    = QUEUES_DEF;
  localparam int TARGET_BEATS = 800;
  localparam int PHASES       = 3;
  localparam int HOLD_FRAMES  = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 600000;

  localparam logic [KEY_W-1:0] KEY_V4      = {80'h0, IPV4_MAPPED, 32'hC0A8_0A01};
  localparam logic [KEY_W-1:0] KEY_V4_ALT  = {80'h0, IPV4_MAPPED, 32'hFFFF_FFFF};
  localparam logic [KEY_W-1:0] KEY_V4_ZERO = {80'h0, IPV4_MAPPED, 32'h0000_0000};
  localparam logic [KEY_W-1:0] KEY_V6      = 128'h2001_0db8_85a3_0000_0000_8a2e_0370_7334;
  localparam logic [KEY_W-1:0] KEY_ONES    = {KEY_W{1'b1}};

  class verdict_board;
    logic [6:0]        cur_pos;
    logic [15:0]       cur_etype;
    logic [KEY_W-1:0]  cur_dst;
    logic [7:0]        cur_queue;
    logic [KEY_W-1:0]  slot_keys [SLOTS];
    logic [2:0]        slot_acts [SLOTS];
    logic              slot_live [SLOTS];
    logic [MASK_W-1:0] sock_mask;
    result_t           verdicts_due [$];
    int                errors;

    function new();
      int i;
      cur_pos   = '0;
      cur_etype = '0;
      cur_dst   = '0;
      cur_queue = '0;
      sock_mask = '0;
      errors    = 0;
      for (i = 0; i < SLOTS; i++) begin
        slot_keys[i] = '0;
        slot_acts[i] = '0;
        slot_live[i] = 1'b0;
      end
    endfunction

    function void set_mask(logic [MASK_W-1:0] m);
      sock_mask = m;
    endfunction

    function void note_beat(item_t it);
      logic [6:0]       p;
      logic [KEY_W-1:0] k;
      result_t          v;
      int               hit_slot;
      int               i;
      bit               ok;
      if (it.operation == OP_TABLE_WRITE) begin
        slot_keys[it.entry_index] = {it.entry_key_high, it.entry_key_low};
        slot_acts[it.entry_index] = it.entry_action;
        slot_live[it.entry_index] = it.entry_valid;
        return;
      end
      p = cur_pos;
      if (p == 7'd0) begin
        cur_queue = it.rx_queue;
        cur_etype = '0;
        cur_dst   = '0;
      end
      if (p == POS_ETYPE_HI || p == POS_ETYPE_LO) cur_etype = {cur_etype[7:0], it.data_byte};
      if ((cur_etype == ETYPE_IPV4 && p >= POS_V4_FIRST && p <= POS_V4_LAST) ||
          (cur_etype == ETYPE_IPV6 && p >= POS_V6_FIRST && p <= POS_V6_LAST))
        cur_dst = {cur_dst[KEY_W-9:0], it.data_byte};
      if (p != POS_SATURATED) cur_pos = p + 7'd1;
      if (!it.last_byte) return;

      cur_pos = '0;
      v.action = ACT_PASS;
      v.address_matched = 1'b0;
      if (p >= POS_MIN_LAST && (cur_etype == ETYPE_IPV4 || cur_etype == ETYPE_IPV6)) begin
        if (cur_etype == ETYPE_IPV6) begin
          ok = (p >= POS_V6_END);
          k  = cur_dst;
        end else begin
          ok = (p >= POS_V4_END);
          k  = {80'h0, IPV4_MAPPED, cur_dst[31:0]};
        end
        if (!ok) begin
          v.action = ACT_ABORTED;
        end else begin
          // lowest live slot with the key wins
          hit_slot = -1;
          for (i = SLOTS - 1; i >= 0; i--)
            if (slot_live[i] && slot_keys[i] == k) hit_slot = i;
          if (hit_slot >= 0) begin
            v.address_matched = 1'b1;
            if (cur_queue < RX_QUEUES && sock_mask[cur_queue[1:0]])
              v.action = ACT_REDIRECT;
            else if (slot_acts[hit_slot] > ACT_REDIRECT)
              v.action = ACT_DROP;
            else
              v.action = slot_acts[hit_slot];
          end
        end
      end
      verdicts_due.push_back(v);
    endfunction

    function void check_verdict(result_t r);
      result_t e;
      if (verdicts_due.size() == 0) begin
        $error("unexpected verdict: action %0d address_matched %0d",
               r.action, r.address_matched);
        errors++;
        return;
      end
      e = verdicts_due.pop_front();
      if (r.action !== e.action) begin
        $error("action: expected %0d, got %0d", e.action, r.action);
        errors++;
      end
      if (r.address_matched !== e.address_matched) begin
        $error("address_matched: expected %0d, got %0d", e.address_matched, r.address_matched);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  item_t             item;
  logic              result_valid;
  logic              result_stall;
  result_t           result;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [MASK_W-1:0] cfg_data;

  verdict_board      board;
  bit                no_idle;
  bit                hold_request;
  int                beats_sent;
  int                cycles = 0;
  logic [KEY_W-1:0]  aim_keys [SLOTS];

  always #1 clk = ~clk;

  vip_packet_classifier dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic item_t noise_item();
    logic [159:0] r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return r[$bits(item_t)-1:0];
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [KEY_W-1:0] mapped_key(logic [31:0] addr);
    return {80'h0, IPV4_MAPPED, addr};
  endfunction

  // Enter and leave at a falling edge; valid stays up after the beat.
  task automatic send_beat(input item_t it);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid = 1'b1;
    item = it;
    do @(posedge clk); while (item_stall);
    board.note_beat(it);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic write_slot(input logic [1:0] idx, input logic [KEY_W-1:0] key,
                            input logic [2:0] act, input logic live);
    item_t it;
    it = noise_item();
    it.operation = OP_TABLE_WRITE;
    it.entry_index = idx;
    {it.entry_key_high, it.entry_key_low} = key;
    it.entry_action = act;
    it.entry_valid = live;
    aim_keys[idx] = key;
    send_beat(it);
  endtask

  task automatic random_write();
    logic [KEY_W-1:0] k;
    k = $urandom_range(0, 1) ? mapped_key($urandom) : random_key();
    write_slot(2'($urandom_range(0, SLOTS - 1)), k, 3'($urandom_range(0, 7)),
               $urandom_range(0, 4) != 0);
  endtask

  task automatic send_frame(input logic [15:0] etype, input int len,
                            input logic [KEY_W-1:0] key, input logic [7:0] q,
                            input bit interleave);
    item_t it;
    int    i;
    for (i = 0; i < len; i++) begin
      it = noise_item();
      it.operation = OP_PACKET;
      if (i == 12) it.data_byte = etype[15:8];
      else if (i == 13) it.data_byte = etype[7:0];
      else if (etype == ETYPE_IPV4 && i >= 30 && i <= 33) it.data_byte = key[8*(33-i) +: 8];
      else if (etype == ETYPE_IPV6 && i >= 38 && i <= 53) it.data_byte = key[8*(53-i) +: 8];
      it.last_byte = (i == len - 1);
      if (i == 0) it.rx_queue = q;
      // drop a table write into the middle of the frame now and then
      if (interleave && $urandom_range(0, 39) == 0) random_write();
      send_beat(it);
    end
  endtask

  task automatic random_frame();
    int               r;
    int               len;
    logic [15:0]      et;
    logic [KEY_W-1:0] k;
    logic [7:0]       q;
    r = $urandom_range(0, 99);
    k = ($urandom_range(0, 9) < 7) ? aim_keys[$urandom_range(0, SLOTS - 1)] : random_key();
    if ($urandom_range(0, 9) < 7) q = 8'($urandom_range(0, RX_QUEUES - 1));
    else q = 8'($urandom_range(0, 255));
    if (r < 8) begin
      et  = $urandom_range(0, 1) ? ETYPE_IPV4 : ETYPE_IPV6;
      len = $urandom_range(1, 14);
    end else if (r < 14) begin
      et  = 16'($urandom_range(0, 65535));
      len = $urandom_range(15, 70);
    end else if (r < 22) begin
      et  = ETYPE_IPV4;
      len = $urandom_range(15, 34);
    end else if (r < 55) begin
      et  = ETYPE_IPV4;
      len = $urandom_range(35, 64);
    end else if (r < 62) begin
      et  = ETYPE_IPV6;
      len = $urandom_range(15, 54);
    end else if (r < 97) begin
      et  = ETYPE_IPV6;
      len = $urandom_range(55, 80);
    end else begin
      et  = $urandom_range(0, 1) ? ETYPE_IPV4 : ETYPE_IPV6;
      len = $urandom_range(120, 150);
    end
    send_frame(et, len, k, q, 1'b1);
  endtask

  // Drain the block before touching the register.
  task automatic settle();
    item_valid = 1'b0;
    while (board.verdicts_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_mask(input logic [MASK_W-1:0] m);
    cfg_valid = 1'b1;
    cfg_data = m;
    do @(posedge clk); while (!cfg_ready);
    board.set_mask(m);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin : result_side
    int n;
    bit held;
    result_stall = 1'b0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !held) begin
        result_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end
      n = draw_gap();
      if (n > 0) begin
        result_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      result_stall = 1'b0;
      do @(posedge clk); while (!result_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) board.check_verdict(result);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** vip_packet_classifier: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int          i;
    int          phase;
    int          beat_goal;
    int          phase_frames;
    logic [3:0]  mask_pick;
    board = new();
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    no_idle = 1'b1;
    hold_request = 1'b0;
    beats_sent = 0;
    for (i = 0; i < SLOTS; i++) aim_keys[i] = random_key();
    repeat (7) @(negedge clk);
    rst = 1'b0;

    write_mask(4'h0);
    write_slot(2'd0, KEY_V4, ACT_TX, 1'b1);
    write_slot(2'd1, KEY_V6, ACT_DROP, 1'b1);
    write_slot(2'd2, KEY_V6, ACT_TX, 1'b1);
    write_slot(2'd3, KEY_V4_ALT, 3'd7, 1'b1);
    send_frame(ETYPE_IPV4, 1, KEY_V4, 8'd0, 1'b0);
    send_frame(ETYPE_IPV4, 14, KEY_V4, 8'd0, 1'b0);
    send_frame(16'h1234, 40, KEY_V4, 8'd0, 1'b0);
    send_frame(ETYPE_IPV4, 15, KEY_V4, 8'd0, 1'b0);
    send_frame(ETYPE_IPV4, 34, KEY_V4, 8'd0, 1'b0);
    send_frame(ETYPE_IPV4, 35, KEY_V4, 8'd0, 1'b0);
    no_idle = 1'b0;
    send_frame(ETYPE_IPV6, 54, KEY_V6, 8'd1, 1'b0);
    send_frame(ETYPE_IPV6, 55, KEY_V6, 8'd1, 1'b0);
    send_frame(ETYPE_IPV4, 40, KEY_V4_ALT, 8'd3, 1'b0);
    send_frame(ETYPE_IPV4, 36, random_key(), 8'd0, 1'b0);
    // mapped key carried in an IPv6 header, frame long enough to saturate
    send_frame(ETYPE_IPV6, 140, KEY_V4, 8'd2, 1'b0);
    write_slot(2'd1, KEY_V6, ACT_DROP, 1'b0);
    write_slot(2'd2, KEY_ONES, ACT_REDIRECT, 1'b1);
    send_frame(ETYPE_IPV6, 60, KEY_V6, 8'd0, 1'b0);
    send_frame(ETYPE_IPV6, 55, KEY_ONES, 8'd0, 1'b0);
    write_slot(2'd1, KEY_V4_ZERO, ACT_ABORTED, 1'b1);
    settle();
    write_mask(4'hF);
    send_frame(ETYPE_IPV4, 35, KEY_V4, 8'd2, 1'b0);
    send_frame(ETYPE_IPV4, 35, KEY_V4, 8'd4, 1'b0);
    send_frame(ETYPE_IPV4, 35, KEY_V4, 8'hFF, 1'b0);
    send_frame(ETYPE_IPV4, 35, KEY_V4_ZERO, 8'd200, 1'b0);
    send_frame(ETYPE_IPV4, 35, random_key(), 8'd0, 1'b0);

    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      if (phase == 0) mask_pick = 4'h0;
      else if (phase == 1) mask_pick = 4'hF;
      else mask_pick = 4'($urandom_range(0, 15));
      write_mask(mask_pick);
      no_idle = (phase == 2);
      if (phase == 2) begin
        // back up the result side with short frames so the job queue fills and input stalls
        hold_request = 1'b1;
        for (i = 0; i < HOLD_FRAMES; i++)
          send_frame(ETYPE_IPV4, $urandom_range(1, 14), aim_keys[0], 8'd0, 1'b0);
      end
      beat_goal = beats_sent + (TARGET_BEATS - beats_sent) / (PHASES - phase);
      phase_frames = 0;
      while (beats_sent < beat_goal || phase_frames < 1) begin
        if ($urandom_range(0, 4) == 0) begin
          random_write();
        end else begin
          random_frame();
          phase_frames++;
        end
      end
    end

    settle();
    repeat (12) @(negedge clk);
    if (board.errors == 0 && board.verdicts_due.size() == 0) begin
      $display("** vip_packet_classifier: PASSED **");
    end else begin
      $display("** vip_packet_classifier: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/vpc_pkg.sv
design/vpc_front.sv
design/vpc_fifo.sv
design/vpc_back.sv
design/vip_packet_classifier.sv
test/tb.sv
